>>> rtl/core/fwfi_pkg.sv
// Package for the front-insert queue: sizes, request codes and the result record.
`default_nettype none
package fwfi_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  localparam int IDX_W     = $clog2(DEPTH);
  localparam int LEVEL_W   = $clog2(DEPTH + 1);
  localparam int REQ_W     = 3;
  localparam int PAYLOAD_W = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_TAIL    = 3'd0,
    REQ_PUSH_HEAD    = 3'd1,
    REQ_INSERT_AFTER = 3'd2,
    REQ_POP_HEAD     = 3'd3,
    REQ_PEEK_HEAD    = 3'd4
  } req_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload_out;
    logic                 payload_valid;
    logic                 overflow;
    logic                 is_empty_now;
    level_t               level;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/fwfi_queue.sv
// Ring-buffer queue storage, head/occupancy state and per-request result logic.
`default_nettype none
module fwfi_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          req_fire,
  input  wire logic [fwfi_pkg::REQ_W-1:0]    req_type,
  input  wire logic [fwfi_pkg::PAYLOAD_W-1:0] payload_in,
  output fwfi_pkg::result_t                  result
);
  import fwfi_pkg::*;

  word_t  slots_r [DEPTH];
  idx_t   head_r, head_nxt;
  level_t occ_r, occ_nxt;

  idx_t   head_prev, head_next, tail_idx;
  logic [LEVEL_W:0] tail_sum;
  word_t  word, head_word;
  logic   is_full, q_empty;

  logic   wr0_en, wr1_en;
  idx_t   wr0_idx, wr1_idx;
  word_t  wr0_data, wr1_data;

  assign word      = WORD_BITS'(payload_in);
  assign head_word = slots_r[head_r];
  assign is_full   = (occ_r == LEVEL_W'(DEPTH));
  assign q_empty   = (occ_r == '0);

  assign head_prev = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_next = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum  = (LEVEL_W + 1)'(head_r) + (LEVEL_W + 1)'(occ_r);
  // sum stays below twice the depth: one compare and subtract wraps it
  assign tail_idx  = (tail_sum >= (LEVEL_W + 1)'(DEPTH))
                     ? IDX_W'(tail_sum - (LEVEL_W + 1)'(DEPTH))
                     : IDX_W'(tail_sum);

  always_comb begin
    head_nxt             = head_r;
    occ_nxt              = occ_r;
    wr0_en               = 1'b0;
    wr0_idx              = head_r;
    wr0_data             = word;
    wr1_en               = 1'b0;
    wr1_idx              = head_r;
    wr1_data             = word;
    result.payload_out   = '0;
    result.payload_valid = 1'b0;
    result.overflow      = 1'b0;

    unique case (req_type)
      REQ_PUSH_TAIL, REQ_PUSH_HEAD, REQ_INSERT_AFTER: begin
        priority if (is_full) begin
          result.overflow = 1'b1;
        end else if (q_empty) begin
          wr0_en  = 1'b1;
          occ_nxt = LEVEL_W'(1);
        end else if (req_type == REQ_PUSH_TAIL) begin
          wr0_en  = 1'b1;
          wr0_idx = tail_idx;
          occ_nxt = occ_r + 1'b1;
        end else if (req_type == REQ_PUSH_HEAD) begin
          wr0_en   = 1'b1;
          wr0_idx  = head_prev;
          head_nxt = head_prev;
          occ_nxt  = occ_r + 1'b1;
        end else begin
          // move old head back one slot, new word takes its place
          wr0_en   = 1'b1;
          wr0_idx  = head_prev;
          wr0_data = head_word;
          wr1_en   = 1'b1;
          head_nxt = head_prev;
          occ_nxt  = occ_r + 1'b1;
        end
      end
      REQ_POP_HEAD, REQ_PEEK_HEAD: begin
        if (!q_empty) begin
          result.payload_out   = PAYLOAD_W'(head_word);
          result.payload_valid = 1'b1;
          if (req_type == REQ_POP_HEAD) begin
            head_nxt = head_next;
            occ_nxt  = occ_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    result.is_empty_now = (occ_nxt == '0);
    result.level        = occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else if (req_fire) begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && wr0_en) begin
      slots_r[wr0_idx] <= wr0_data;
    end
    if (req_fire && wr1_en) begin
      slots_r[wr1_idx] <= wr1_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/fifo_with_front_insert_unit.sv
// Top level of the queue with push at head or tail, insert-after-head and a registered result.
//
//  channel | direction | ports                                          | transfer when
//  in      | input     | in_req_type, in_payload_in                     | in_valid & in_ready
//  out     | output    | out_payload_out, out_payload_valid, out_overflow,
//          |           | out_is_empty_now, out_level                    | out_valid & out_ready
//
// One request per cycle while the result is not stalled; the result is registered and
// shows in the cycle after the input transfer. Queue state (head slot, occupancy) and
// slot writes are registered along with it, so the next request sees them at once.
// Reset empties the queue; slot contents are never read before being written.
// A stalled result holds the output register and in_ready drops until it moves.
`default_nettype none
module fifo_with_front_insert_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [fwfi_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [fwfi_pkg::PAYLOAD_W-1:0]  in_payload_in,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [fwfi_pkg::PAYLOAD_W-1:0]  out_payload_out,
  output      logic                            out_payload_valid,
  output      logic                            out_overflow,
  output      logic                            out_is_empty_now,
  output      logic [fwfi_pkg::LEVEL_W-1:0]    out_level
);
  import fwfi_pkg::*;

  logic    in_fire;
  logic    out_valid_r;
  result_t res, res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  fwfi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_fire   (in_fire),
    .req_type   (in_req_type),
    .payload_in (in_payload_in),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_out   = res_r.payload_out;
  assign out_payload_valid = res_r.payload_valid;
  assign out_overflow      = res_r.overflow;
  assign out_is_empty_now  = res_r.is_empty_now;
  assign out_level         = res_r.level;

endmodule
`default_nettype wire

>>> rtl/core/fwfi_checker.sv
// Port-level checks on the front-insert queue result channel, bound to the top level.
`default_nettype none
module fwfi_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [fwfi_pkg::PAYLOAD_W-1:0]  out_payload_out,
  input wire logic                            out_payload_valid,
  input wire logic                            out_overflow,
  input wire logic                            out_is_empty_now,
  input wire logic [fwfi_pkg::LEVEL_W-1:0]    out_level
);
  import fwfi_pkg::*;

  // stalled result holds valid, payload and level
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_out) && $stable(out_level))
    else $error("result changed while stalled");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty_now == (out_level == '0))
    else $error("empty flag disagrees with level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= LEVEL_W'(DEPTH) && !(out_overflow && out_level != LEVEL_W'(DEPTH)))
    else $error("level out of range or overflow below full");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_out == '0)
    else $error("payload without valid flag");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_payload_valid && out_overflow))
    else $error("data and overflow flagged together");

endmodule

bind fifo_with_front_insert_unit fwfi_checker u_fwfi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_payload_out   (out_payload_out),
  .out_payload_valid (out_payload_valid),
  .out_overflow      (out_overflow),
  .out_is_empty_now  (out_is_empty_now),
  .out_level         (out_level)
);
`default_nettype wire
